### hw/rtl/plc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinned LRU tag store package
// Shared sizes, result codes, controller states and cell interface types.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TAG_W  = 32;
   localparam int PIN_W  = 16;
   localparam int STAMP_W = 32;
   localparam int SLOT_W = 4;
   localparam int KIND_W = 3;
   localparam int CSR_W  = 5;

   localparam logic [CSR_W-1:0] CACHE_SIZE_RESET = CSR_W'(16);
   localparam logic [PIN_W-1:0] PIN_MAX = '1;

   localparam logic [KIND_W-1:0] KIND_EVICT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HIT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FILL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNLOAD = 3'd4;
   localparam logic [KIND_W-1:0] KIND_UMISS  = 3'd5;

   localparam logic FUNC_UNLOAD = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_EVICT,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic fill;
      logic load_hit;
      logic unload;
      logic evict;
   } cell_cmd_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic               free_first;
      logic [TAG_W-1:0]   tag;
      logic [PIN_W-1:0]   pins;
      logic [STAMP_W-1:0] stamp;
   } cell_stat_type;

endpackage
`default_nettype wire

### hw/rtl/plc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinned LRU tag store cell
// One entry: valid bit, tag, pin count and stamp, with a lowest-free chain link.
// ----------------------------------------------------------------------------
module plc_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire plc_pkg::cell_cmd_type         cmd,
   input  wire logic [plc_pkg::TAG_W-1:0]     tag_in,
   input  wire logic [plc_pkg::STAMP_W-1:0]   stamp_in,
   input  wire logic                          free_seen_in,
   output logic                               free_seen_out,
   output plc_pkg::cell_stat_type             stat
);

   logic                          valid_ff;
   logic [plc_pkg::TAG_W-1:0]     tag_ff;
   logic [plc_pkg::PIN_W-1:0]     pins_ff;
   logic [plc_pkg::STAMP_W-1:0]   stamp_ff;

   // A free cell is the lowest free one when no cell before it was free.
   assign free_seen_out   = free_seen_in | ~valid_ff;
   assign stat.valid      = valid_ff;
   assign stat.hit        = valid_ff && (tag_ff == tag_in);
   assign stat.free_first = ~valid_ff & ~free_seen_in;
   assign stat.tag        = tag_ff;
   assign stat.pins       = pins_ff;
   assign stat.stamp      = stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.fill) begin
         valid_ff <= 1'b1;
      end else if (cmd.evict) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         tag_ff   <= tag_in;
         pins_ff  <= plc_pkg::PIN_W'(1);
         stamp_ff <= stamp_in;
      end else if (cmd.load_hit) begin
         if (pins_ff != plc_pkg::PIN_MAX) begin
            pins_ff <= pins_ff + plc_pkg::PIN_W'(1);
         end
         stamp_ff <= stamp_in;
      end else if (cmd.unload) begin
         if (pins_ff != '0) begin
            pins_ff <= pins_ff - plc_pkg::PIN_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/pinned_lru_block_cache_tags_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pinned LRU block cache tag store
// Fully associative tag store with pin counts and LRU eviction of unpinned
// entries, built as a row of entry cells under a small controller.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low. Results come back one per
// cycle at most on the rsp_ ports, each marked by rsp_valid for exactly one
// cycle, and the receiver must take them as they come since it cannot stall
// the block. A load that hits and any unload are answered from the look-up
// state. A load that misses is filled or refused from the fill state after
// any evictions it needs; the least recently used unpinned entry for each
// eviction is found by sweeping the cells one per cycle through a single
// shared age comparator. A sweep that finds no unpinned entry while the store
// is still at or above its target adds no result before the fill or refusal.
// The final result of every item carries rsp_last, and busy is low again in
// the cycle that result is shown, so a new item may be issued then. Write
// cache_size through the csr_ port only while busy is low.
// ----------------------------------------------------------------------------
module pinned_lru_block_cache_tags_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_func,
   input  wire logic [plc_pkg::TAG_W-1:0]     req_block_offset,
   output logic                               rsp_valid,
   output logic [plc_pkg::KIND_W-1:0]         rsp_kind,
   output logic [plc_pkg::TAG_W-1:0]          rsp_tag_offset,
   output logic [plc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [plc_pkg::PIN_W-1:0]          rsp_pin_count,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [plc_pkg::CSR_W-1:0]     csr_data
);

   plc_pkg::state_type state_ff, state_in;

   logic [plc_pkg::CSR_W-1:0]     cache_size_ff;
   logic                          func_ff;
   logic [plc_pkg::TAG_W-1:0]     tag_ff;
   logic [plc_pkg::STAMP_W-1:0]   clock_ff, clock_in;
   logic [plc_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [plc_pkg::IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [plc_pkg::IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [plc_pkg::STAMP_W-1:0]   best_age_ff, best_age_in;
   logic                          found_ff, found_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [plc_pkg::KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [plc_pkg::TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [plc_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [plc_pkg::PIN_W-1:0]     rsp_pins_ff, rsp_pins_in;
   logic                          rsp_last_ff, rsp_last_in;

   plc_pkg::cell_cmd_type  cmd  [plc_pkg::DEPTH];
   plc_pkg::cell_stat_type stat [plc_pkg::DEPTH];
   logic [plc_pkg::DEPTH:0] free_chain;

   logic                          hit_any;
   logic [plc_pkg::IDX_W-1:0]     hit_idx;
   logic [plc_pkg::PIN_W-1:0]     hit_pins;
   logic                          free_any;
   logic [plc_pkg::IDX_W-1:0]     free_idx;
   logic [31:0]                   target;
   logic                          need_evict;
   logic                          need_more;
   logic                          cand;
   logic [plc_pkg::STAMP_W-1:0]   cand_age;
   logic                          better;
   logic                          scan_end;

   // The cells form a row: each hands the "free cell seen" flag to the next,
   // so exactly one free cell claims the fill.
   assign free_chain[0] = 1'b0;

   for (genvar g = 0; g < plc_pkg::DEPTH; g++) begin : g_cell
      plc_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd[g]),
         .tag_in        (tag_ff),
         .stamp_in      (clock_ff),
         .free_seen_in  (free_chain[g]),
         .free_seen_out (free_chain[g+1]),
         .stat          (stat[g])
      );
   end

   // Tags of valid entries are unique, so at most one cell reports a hit.
   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = 0; i < plc_pkg::DEPTH; i++) begin
         if (stat[i].hit) begin
            hit_any = 1'b1;
            hit_idx = plc_pkg::IDX_W'(i);
         end
         if (stat[i].free_first) begin
            free_any = 1'b1;
            free_idx = plc_pkg::IDX_W'(i);
         end
      end
   end

   assign hit_pins = stat[hit_idx].pins;

   // Targets above the store depth behave as the depth itself.
   always_comb begin
      target = 32'(cache_size_ff);
      if (target > 32'(plc_pkg::DEPTH)) begin
         target = 32'(plc_pkg::DEPTH);
      end
   end

   assign need_evict = 32'(count_ff) >= target;
   assign need_more  = (32'(count_ff) - 32'd1) >= target;

   // Shared age comparator for the eviction sweep.
   assign cand     = stat[scan_idx_ff].valid && (stat[scan_idx_ff].pins == '0);
   assign cand_age = clock_ff - stat[scan_idx_ff].stamp;
   assign better   = cand && (!found_ff || (cand_age > best_age_ff));
   assign scan_end = scan_idx_ff == plc_pkg::IDX_W'(plc_pkg::DEPTH - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = plc_pkg::ST_LOOK;
            end
         end
         plc_pkg::ST_LOOK: begin
            if (func_ff == plc_pkg::FUNC_UNLOAD || hit_any) begin
               state_in = plc_pkg::ST_IDLE;
            end else if (need_evict) begin
               state_in = plc_pkg::ST_SCAN;
            end else begin
               state_in = plc_pkg::ST_FILL;
            end
         end
         plc_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = (found_ff || better) ? plc_pkg::ST_EVICT : plc_pkg::ST_FILL;
            end
         end
         plc_pkg::ST_EVICT: begin
            state_in = need_more ? plc_pkg::ST_SCAN : plc_pkg::ST_FILL;
         end
         plc_pkg::ST_FILL: begin
            state_in = plc_pkg::ST_IDLE;
         end
         default: begin
            state_in = plc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs, cell commands and datapath updates.
   always_comb begin
      clock_in     = clock_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_pins_in  = rsp_pins_ff;
      rsp_last_in  = rsp_last_ff;
      for (int i = 0; i < plc_pkg::DEPTH; i++) begin
         cmd[i] = '0;
      end
      case (state_ff)
         plc_pkg::ST_LOOK: begin
            rsp_tag_in  = tag_ff;
            rsp_last_in = 1'b1;
            if (func_ff == plc_pkg::FUNC_UNLOAD) begin
               rsp_valid_in = 1'b1;
               if (hit_any) begin
                  cmd[hit_idx].unload = 1'b1;
                  rsp_kind_in = plc_pkg::KIND_UNLOAD;
                  rsp_slot_in = plc_pkg::SLOT_W'(hit_idx);
                  rsp_pins_in = (hit_pins != '0) ? hit_pins - plc_pkg::PIN_W'(1) : hit_pins;
               end else begin
                  rsp_kind_in = plc_pkg::KIND_UMISS;
                  rsp_slot_in = '0;
                  rsp_pins_in = '0;
               end
            end else if (hit_any) begin
               rsp_valid_in = 1'b1;
               cmd[hit_idx].load_hit = 1'b1;
               clock_in    = clock_ff + plc_pkg::STAMP_W'(1);
               rsp_kind_in = plc_pkg::KIND_HIT;
               rsp_slot_in = plc_pkg::SLOT_W'(hit_idx);
               rsp_pins_in = (hit_pins != plc_pkg::PIN_MAX) ?
                             hit_pins + plc_pkg::PIN_W'(1) : hit_pins;
            end else begin
               scan_idx_in = '0;
               found_in    = 1'b0;
            end
         end
         plc_pkg::ST_SCAN: begin
            if (better) begin
               best_idx_in = scan_idx_ff;
               best_age_in = cand_age;
               found_in    = 1'b1;
            end
            scan_idx_in = scan_idx_ff + plc_pkg::IDX_W'(1);
         end
         plc_pkg::ST_EVICT: begin
            cmd[best_idx_ff].evict = 1'b1;
            count_in     = count_ff - plc_pkg::CNT_W'(1);
            scan_idx_in  = '0;
            found_in     = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = plc_pkg::KIND_EVICT;
            rsp_tag_in   = stat[best_idx_ff].tag;
            rsp_slot_in  = plc_pkg::SLOT_W'(best_idx_ff);
            rsp_pins_in  = '0;
            rsp_last_in  = 1'b0;
         end
         plc_pkg::ST_FILL: begin
            rsp_valid_in = 1'b1;
            rsp_tag_in   = tag_ff;
            rsp_last_in  = 1'b1;
            if (free_any) begin
               cmd[free_idx].fill = 1'b1;
               clock_in    = clock_ff + plc_pkg::STAMP_W'(1);
               count_in    = count_ff + plc_pkg::CNT_W'(1);
               rsp_kind_in = plc_pkg::KIND_FILL;
               rsp_slot_in = plc_pkg::SLOT_W'(free_idx);
               rsp_pins_in = plc_pkg::PIN_W'(1);
            end else begin
               rsp_kind_in = plc_pkg::KIND_FULL;
               rsp_slot_in = '0;
               rsp_pins_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= plc_pkg::ST_IDLE;
         cache_size_ff <= plc_pkg::CACHE_SIZE_RESET;
         clock_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         if (csr_valid) begin
            cache_size_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == plc_pkg::ST_IDLE && start) begin
         func_ff <= req_func;
         tag_ff  <= req_block_offset;
      end
      scan_idx_ff <= scan_idx_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_pins_ff <= rsp_pins_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy           = state_ff != plc_pkg::ST_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_tag_offset = rsp_tag_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_pin_count  = rsp_pins_ff;
   assign rsp_last       = rsp_last_ff;

   // An item ends only with its final result on the ports.
   a_end_with_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_valid && rsp_last))
      else $error("item finished without a final result");

   // The entry count never exceeds the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(plc_pkg::DEPTH))
      else $error("entry count above depth");

   // Evictions are never final and report no pins.
   a_evict_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == plc_pkg::KIND_EVICT) |-> (!rsp_last && rsp_pin_count == '0))
      else $error("malformed eviction result");

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pinned LRU block cache tag store testbench
// Drives load and unload items into the tag store, predicts every result with
// a behavioral copy of the store, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;

   // Result item as it appears on the rsp_ ports.
   typedef struct packed {
      logic [plc_pkg::KIND_W-1:0]  kind;
      logic [plc_pkg::TAG_W-1:0]   tag_offset;
      logic [plc_pkg::SLOT_W-1:0]  slot;
      logic [plc_pkg::PIN_W-1:0]   pin_count;
      logic                        last;
   } cache_result_type;

   // One row of the directed table. When check_kind is set, the predicted kind
   // of the final result is compared against the typed-in value as well.
   typedef struct {
      logic                       func;
      logic [plc_pkg::TAG_W-1:0]  offset;
      bit                         check_kind;
      logic [plc_pkg::KIND_W-1:0] final_kind;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [plc_pkg::TAG_W-1:0] req_block_offset = '0;
   logic rsp_valid;
   logic [plc_pkg::KIND_W-1:0] rsp_kind;
   logic [plc_pkg::TAG_W-1:0] rsp_tag_offset;
   logic [plc_pkg::SLOT_W-1:0] rsp_slot;
   logic [plc_pkg::PIN_W-1:0] rsp_pin_count;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [plc_pkg::CSR_W-1:0] csr_data = '0;

   pinned_lru_block_cache_tags_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_block_offset(req_block_offset),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_tag_offset(rsp_tag_offset),
      .rsp_slot(rsp_slot), .rsp_pin_count(rsp_pin_count), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted copy of the tag store.
   logic [plc_pkg::CSR_W-1:0]   shadow_target;
   bit                          shadow_valid [plc_pkg::DEPTH];
   logic [plc_pkg::TAG_W-1:0]   shadow_tag   [plc_pkg::DEPTH];
   logic [plc_pkg::PIN_W-1:0]   shadow_pins  [plc_pkg::DEPTH];
   logic [plc_pkg::STAMP_W-1:0] shadow_stamp [plc_pkg::DEPTH];
   logic [plc_pkg::STAMP_W-1:0] shadow_clock;
   int                          shadow_count;

   cache_result_type pending_results[$];
   int error_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int evictions_seen = 0;
   int refusals_seen = 0;
   int sender_idle_pct = 0;

   // One line per mismatch, and a count for the final verdict.
   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   function automatic void reset_shadow();
      shadow_target = plc_pkg::CACHE_SIZE_RESET;
      shadow_clock = '0;
      shadow_count = 0;
      for (int i = 0; i < plc_pkg::DEPTH; i++) begin
         shadow_valid[i] = 0;
      end
   endfunction

   function automatic cache_result_type make_result(logic [plc_pkg::KIND_W-1:0] k,
                                                    logic [plc_pkg::TAG_W-1:0] t, int s,
                                                    logic [plc_pkg::PIN_W-1:0] p, logic l);
      cache_result_type r;
      r.kind = k;
      r.tag_offset = t;
      r.slot = plc_pkg::SLOT_W'(s);
      r.pin_count = p;
      r.last = l;
      return r;
   endfunction

   // Works out the results of one load or unload and queues them in order.
   function automatic void predict_access(logic func, logic [plc_pkg::TAG_W-1:0] offset);
      int hit_slot;
      int victim;
      int free_slot;
      int limit;
      logic [plc_pkg::STAMP_W-1:0] oldest_age;
      hit_slot = -1;
      for (int i = plc_pkg::DEPTH - 1; i >= 0; i--) begin
         if (shadow_valid[i] && shadow_tag[i] == offset) hit_slot = i;
      end
      if (func == plc_pkg::FUNC_UNLOAD) begin
         if (hit_slot < 0) begin
            pending_results.push_back(make_result(plc_pkg::KIND_UMISS, offset, 0, '0, 1'b1));
         end else begin
            if (shadow_pins[hit_slot] != '0) shadow_pins[hit_slot]--;
            pending_results.push_back(make_result(plc_pkg::KIND_UNLOAD, offset, hit_slot,
                                                  shadow_pins[hit_slot], 1'b1));
         end
         return;
      end
      if (hit_slot >= 0) begin
         if (shadow_pins[hit_slot] != plc_pkg::PIN_MAX) shadow_pins[hit_slot]++;
         shadow_stamp[hit_slot] = shadow_clock;
         shadow_clock++;
         pending_results.push_back(make_result(plc_pkg::KIND_HIT, offset, hit_slot,
                                               shadow_pins[hit_slot], 1'b1));
         return;
      end
      limit = (shadow_target > plc_pkg::DEPTH) ? plc_pkg::DEPTH : int'(shadow_target);
      while (shadow_count >= limit) begin
         victim = -1;
         oldest_age = '0;
         for (int i = 0; i < plc_pkg::DEPTH; i++) begin
            if (shadow_valid[i] && shadow_pins[i] == '0) begin
               if (victim < 0 || (shadow_clock - shadow_stamp[i]) > oldest_age) begin
                  victim = i;
                  oldest_age = shadow_clock - shadow_stamp[i];
               end
            end
         end
         if (victim < 0) break;
         shadow_valid[victim] = 0;
         shadow_count--;
         pending_results.push_back(make_result(plc_pkg::KIND_EVICT, shadow_tag[victim],
                                               victim, '0, 1'b0));
      end
      free_slot = -1;
      for (int i = plc_pkg::DEPTH - 1; i >= 0; i--) begin
         if (!shadow_valid[i]) free_slot = i;
      end
      if (free_slot < 0) begin
         pending_results.push_back(make_result(plc_pkg::KIND_FULL, offset, 0, '0, 1'b1));
         return;
      end
      shadow_valid[free_slot] = 1;
      shadow_tag[free_slot] = offset;
      shadow_pins[free_slot] = plc_pkg::PIN_W'(1);
      shadow_stamp[free_slot] = shadow_clock;
      shadow_clock++;
      shadow_count++;
      pending_results.push_back(make_result(plc_pkg::KIND_FILL, offset, free_slot,
                                            plc_pkg::PIN_W'(1), 1'b1));
   endfunction

   // Every result is taken in the cycle it is shown; the block allows no stall.
   always @(posedge clock) begin
      cache_result_type seen;
      cache_result_type want;
      if (!reset && rsp_valid) begin
         seen = {rsp_kind, rsp_tag_offset, rsp_slot, rsp_pin_count, rsp_last};
         results_seen++;
         if (rsp_kind == plc_pkg::KIND_EVICT) evictions_seen++;
         if (rsp_kind == plc_pkg::KIND_FULL) refusals_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %p", seen));
         end else begin
            want = pending_results.pop_front();
            if (seen.kind != want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", seen.kind, want.kind));
            if (seen.tag_offset != want.tag_offset)
               report_mismatch($sformatf("tag_offset %h, expected %h",
                                         seen.tag_offset, want.tag_offset));
            if (seen.slot != want.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", seen.slot, want.slot));
            if (seen.pin_count != want.pin_count)
               report_mismatch($sformatf("pin_count %0d, expected %0d",
                                         seen.pin_count, want.pin_count));
            if (seen.last != want.last)
               report_mismatch($sformatf("last %0d, expected %0d", seen.last, want.last));
         end
      end
   end

   // Raises start and holds it until the block takes the item. The prediction
   // is made at the accepting edge, before any of its results can come back.
   // Start drops as each item is taken, while the block is busy with it anyway,
   // so no issue slot is lost.
   task automatic issue_item(input logic func, input logic [plc_pkg::TAG_W-1:0] offset);
      @(posedge clock);
      while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct)
         @(posedge clock);
      start <= 1'b1;
      req_func <= func;
      req_block_offset <= offset;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_access(func, offset);
      items_sent++;
      start <= 1'b0;
      req_func <= 1'($urandom);
      req_block_offset <= $urandom;
   endtask

   // Waits for all predicted results, then lets the longest eviction sweep
   // of an item that produces nothing further drain before going on.
   task automatic drain_results();
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (plc_pkg::DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_target(input logic [plc_pkg::CSR_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_target = value;
      csr_valid <= 1'b0;
   endtask

   // Random offsets come mostly from a small pool so that hits, unloads of
   // resident blocks and evictions are frequent; the rest are fully random.
   function automatic logic [plc_pkg::TAG_W-1:0] pick_offset(int pool);
      if ($urandom_range(9, 0) == 0) return $urandom;
      return plc_pkg::TAG_W'($urandom_range(pool - 1, 0)) * 32'h0001_0000 + 32'h0000_1000;
   endfunction

   initial begin
      directed_row_type table_rows[$];
      logic [plc_pkg::CSR_W-1:0] targets[6];
      int pools[6];
      reset_shadow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: an unload on an empty store, fills at the offset
      // extremes, a hit, unloads down to zero and past it, then refusal
      // once everything is pinned at a target of one.
      table_rows.push_back('{plc_pkg::FUNC_UNLOAD, 32'h0000_0000, 1, plc_pkg::KIND_UMISS});
      table_rows.push_back('{1'b0, 32'h0000_0000, 1, plc_pkg::KIND_FILL});
      table_rows.push_back('{1'b0, 32'hFFFF_FFFF, 1, plc_pkg::KIND_FILL});
      table_rows.push_back('{1'b0, 32'h0000_0000, 1, plc_pkg::KIND_HIT});
      table_rows.push_back('{plc_pkg::FUNC_UNLOAD, 32'h0000_0000, 1, plc_pkg::KIND_UNLOAD});
      table_rows.push_back('{plc_pkg::FUNC_UNLOAD, 32'h0000_0000, 1, plc_pkg::KIND_UNLOAD});
      table_rows.push_back('{plc_pkg::FUNC_UNLOAD, 32'h0000_0000, 1, plc_pkg::KIND_UNLOAD});
      table_rows.push_back('{plc_pkg::FUNC_UNLOAD, 32'hFFFF_FFFF, 1, plc_pkg::KIND_UNLOAD});
      table_rows.push_back('{plc_pkg::FUNC_UNLOAD, 32'hAAAA_5555, 1, plc_pkg::KIND_UMISS});
      for (int i = 0; i < plc_pkg::DEPTH; i++)
         table_rows.push_back('{1'b0, plc_pkg::TAG_W'(32'h5555_AAAA + i), 0,
                                plc_pkg::KIND_FILL});
      foreach (table_rows[i]) begin
         issue_item(table_rows[i].func, table_rows[i].offset);
         if (table_rows[i].check_kind &&
             pending_results[pending_results.size() - 1].kind != table_rows[i].final_kind)
            report_mismatch($sformatf("directed row %0d predicts an unexpected kind", i));
      end

      // Target of one with every slot pinned: a new load must be refused.
      write_target(1);
      issue_item(1'b0, 32'h1234_5678);
      issue_item(1'b0, 32'h8765_4321);
      // Unpin two entries; a target of zero then evicts all unpinned ones.
      issue_item(plc_pkg::FUNC_UNLOAD, 32'h5555_AAAA);
      issue_item(plc_pkg::FUNC_UNLOAD, 32'h5555_AAAB);
      write_target(0);
      issue_item(1'b0, 32'hDEAD_BEEF);

      // Random phases across several targets, including both extremes and
      // a value above the store depth.
      targets = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd9};
      pools = '{24, 6, 40, 10, 8, 20};
      for (int p = 0; p < 6; p++) begin
         write_target(targets[p]);
         case (p % 4)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 49;
            2: sender_idle_pct = 26;
            default: sender_idle_pct = 0;
         endcase
         for (int n = 0; n < 56; n++) begin
            logic func;
            logic [plc_pkg::TAG_W-1:0] offset;
            // Loads outnumber unloads so the store fills and evicts.
            func = ($urandom_range(99, 0) < 40) ? plc_pkg::FUNC_UNLOAD : 1'b0;
            offset = pick_offset(pools[p]);
            issue_item(func, offset);
            if (n == 28) begin
               // Hold off until the store has answered everything so far.
               while (pending_results.size() != 0) @(posedge clock);
            end
         end
      end

      drain_results();
      $display("Covered %0d items and %0d results, including %0d evictions and %0d refusals,",
               items_sent, results_seen, evictions_seen, refusals_seen);
      $display("over cache_size settings from 0 to 31 with and without sender gaps.");
      if (error_count == 0) begin
         $display("pinned_lru_block_cache_tags_core regression: pass");
      end else begin
         $display("pinned_lru_block_cache_tags_core regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("pinned_lru_block_cache_tags_core regression: fail");
      $finish;
   end

endmodule
